// ----- sv/svp_pkg.sv -----
// ----------------------------------------------------------------------------
// svp_pkg: shared constants, tables and types for the sprite projection block
// Screen geometry, CORDIC arctangent table, derived projection constants and
// the item types passed between the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package svp_pkg;

   localparam int SCREEN_WIDTH  = 1280;
   localparam int SCREEN_HEIGHT = 800;
   localparam int CELL_SIZE     = 64;
   localparam int VIEW_ANGLE    = 10923;
   localparam int CORDIC_STEPS  = 16;

   localparam int ATAN_ENTRIES = 24;
   localparam int STEPS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
   localparam int SQRT_BITS = 16;

   localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
   localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
   localparam logic [31:0] FLIP_HIGH    = 32'hC000_0000;
   localparam longint MARGIN_ANGLE = 136713055;
   localparam longint GAIN_COMP    = 652032874;

   // visibility threshold: half view angle plus 0.2 rad, in 32-bit binary angle
   localparam logic [32:0] VIS_LIMIT = 33'(longint'(VIEW_ANGLE) * 32768 + MARGIN_ANGLE);

   localparam logic [31:0] ATAN_TABLE [ATAN_ENTRIES] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
      32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
      32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
   };

   // rotation CORDIC on the constant half view angle, evaluated at elaboration
   function automatic longint view_cordic(input bit want_sin);
      longint x;
      longint y;
      longint z;
      longint t;
      x = GAIN_COMP;
      y = 0;
      z = longint'(VIEW_ANGLE) * 32768;
      for (int i = 0; i < STEPS; i++) begin
         if (z >= 0) begin
            t = x - (y >>> i);
            y = y + (x >>> i);
            z = z - longint'(ATAN_TABLE[i]);
         end else begin
            t = x + (y >>> i);
            y = y - (x >>> i);
            z = z + longint'(ATAN_TABLE[i]);
         end
         x = t;
      end
      return want_sin ? y : x;
   endfunction

   localparam longint VIEW_COS_RAW = view_cordic(1'b0);
   localparam longint VIEW_SIN_RAW = view_cordic(1'b1);
   localparam longint VIEW_COS = (VIEW_COS_RAW < 0) ? 0 : VIEW_COS_RAW;
   localparam longint VIEW_SIN = (VIEW_SIN_RAW <= 0) ? 1 : VIEW_SIN_RAW;

   // distance to projection plane, Q.16
   localparam longint DPP = (longint'(SCREEN_WIDTH / 2) * VIEW_COS * 65536) / VIEW_SIN;
   localparam int DPP_W = $clog2(DPP + 2);
   localparam longint SIZE_NUM = longint'(CELL_SIZE) * DPP;
   localparam int NUM_W = $clog2(SIZE_NUM + 2);
   localparam longint SIZE_SAT = SIZE_NUM >> 16;

   localparam int PERP_W = 30;
   localparam int PROD_W = 32 + DPP_W;
   localparam int OFFS_Q_W = DPP_W + 2;
   localparam int OFW = (OFFS_Q_W + 1 > 22) ? OFFS_Q_W + 1 : 22;
   localparam int SW = ((NUM_W > PERP_W + 16) ? NUM_W : PERP_W + 16) + 1;
   localparam int OW = DPP_W + 34;
   localparam int LOOP_N = (STEPS > SQRT_BITS) ? STEPS : SQRT_BITS;
   localparam int DIV_N = (OFFS_Q_W > 16) ? OFFS_Q_W : 16;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;

   typedef struct packed {
      logic [11:0] player_x;
      logic [11:0] player_y;
      logic [15:0] player_heading;
   } svp_cfg_type;

   typedef struct packed {
      logic signed [12:0] dx;
      logic signed [12:0] dy;
      logic [31:0]        diff;
      logic [15:0]        boff;
      logic               vis;
   } svp_item_type;

   typedef struct packed {
      logic               visible;
      logic [15:0]        bearing_offset;
      logic [15:0]        sprite_distance;
      logic [15:0]        projected_size;
      logic [9:0]         top_row;
      logic [9:0]         bottom_row;
      logic signed [15:0] left_column;
      logic signed [15:0] right_column;
   } svp_result_type;

endpackage

// ----- sv/sprite_view_projection.sv -----
// ----------------------------------------------------------------------------
// sprite_view_projection: billboard sprite placement for a ray-cast view
// Register block, front end (bearing), request queue and back end (placement).
// ----------------------------------------------------------------------------
// Usage:
//  - Program player_x (0x0), player_y (0x4) and player_heading (0x8) over the
//    csr_ port; pready is always high, writes land on the access cycle.
//  - Each request on req_ carries one sprite map position; each produces
//    exactly one response on rsp_ with visibility, bearing, distance, size
//    and clamped/saturated screen edges (hidden sprites: only bearing set).
//  - Throughput: one request per clock while rsp_tready is high. Every stage is a
//    register stage: CORDIC iterations, square-root bits and divider bits each get one.
//  - Pipeline: (STEPS + 2) front stages, the queue, then the back stages,
//    6 + max(16, STEPS) + max(16, DPP_W + 2) of them. With the default
//    constants the offset divider's quotient width sets the divider length.
//  - Stall: when rsp_tready is low with a response waiting the back end holds;
//    the four-entry queue lets the front end keep taking requests until it
//    fills, after which req_tready drops.
//  - Reset (synchronous): configuration registers return to zero, all pipes
//    and the queue empty. No clearing pass is needed.
// ----------------------------------------------------------------------------
module sprite_view_projection (
   input  logic         clock,
   input  logic         reset,
   // configuration
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready,
   // requests
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [23:0]  req_tdata,   // [11:0] sprite_x, [23:12] sprite_y
   // responses
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,   // [15:0] bearing_offset, [31:16] sprite_distance,
                                     // [47:32] projected_size, [57:48] top_row,
                                     // [67:58] bottom_row, [83:68] left_column,
                                     // [99:84] right_column, rest zero
   output logic [0:0]   rsp_tuser    // [0] visible
);
   import svp_pkg::*;

   localparam logic [1:0] REG_PLAYER_X  = 2'd0;
   localparam logic [1:0] REG_PLAYER_Y  = 2'd1;
   localparam logic [1:0] REG_HEADING   = 2'd2;

   logic [11:0] px_ff;
   logic [11:0] py_ff;
   logic [15:0] hd_ff;
   logic        csr_wr;
   svp_cfg_type cfg;

   logic         f_valid;
   logic         q_full;
   logic         q_empty;
   logic         b_pop;
   svp_item_type f_item;
   svp_item_type q_item;
   svp_result_type res;

   // --- register block
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         px_ff <= '0;
         py_ff <= '0;
         hd_ff <= '0;
      end else if (csr_wr) begin
         unique case (csr_paddr[3:2])
            REG_PLAYER_X: px_ff <= csr_pwdata[11:0];
            REG_PLAYER_Y: py_ff <= csr_pwdata[11:0];
            REG_HEADING:  hd_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_PLAYER_X: csr_prdata = {20'h0, px_ff};
         REG_PLAYER_Y: csr_prdata = {20'h0, py_ff};
         REG_HEADING:  csr_prdata = {16'h0, hd_ff};
         default:      csr_prdata = 32'h0;
      endcase
   end

   assign cfg.player_x       = px_ff;
   assign cfg.player_y       = py_ff;
   assign cfg.player_heading = hd_ff;

   // --- front end: bearing and visibility
   svp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .sprite_x  (req_tdata[11:0]),
      .sprite_y  (req_tdata[23:12]),
      .out_valid (f_valid),
      .out_ready (!q_full),
      .out_item  (f_item)
   );

   // --- queue between the two halves
   svp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (f_valid),
      .push_item (f_item),
      .full      (q_full),
      .pop       (b_pop),
      .empty     (q_empty),
      .head_item (q_item)
   );

   // --- back end: distance, size, placement, output register
   svp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (!q_empty),
      .in_item    (q_item),
      .in_pop     (b_pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (res)
   );

   assign rsp_tuser = res.visible;
   assign rsp_tdata = {4'h0,
                       res.right_column,
                       res.left_column,
                       res.bottom_row,
                       res.top_row,
                       res.projected_size,
                       res.sprite_distance,
                       res.bearing_offset};

endmodule

// ----- sv/svp_front.sv -----
// ----------------------------------------------------------------------------
// svp_front: request intake, vectoring CORDIC bearing and visibility test
// Pipelined atan2 of the player-to-sprite vector, one iteration per stage,
// then heading difference, wrap, rounding and the field-of-view compare.
// ----------------------------------------------------------------------------
module svp_front (
   input  logic                 clock,
   input  logic                 reset,
   input  svp_pkg::svp_cfg_type cfg,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [11:0]          sprite_x,
   input  logic [11:0]          sprite_y,
   output logic                 out_valid,
   input  logic                 out_ready,
   output svp_pkg::svp_item_type out_item
);
   import svp_pkg::*;

   logic en;
   logic               v_ff    [STEPS+1];
   logic signed [31:0] cx_ff   [STEPS+1];
   logic signed [31:0] cy_ff   [STEPS+1];
   logic [31:0]        cz_ff   [STEPS+1];
   logic               zero_ff [STEPS+1];
   logic signed [12:0] dx_ff   [STEPS+1];
   logic signed [12:0] dy_ff   [STEPS+1];
   logic               iv_ff;
   svp_item_type       item_ff;
   svp_item_type       item_in;

   logic signed [12:0] dx_in;
   logic signed [12:0] dy_in;
   logic signed [31:0] x_in;
   logic signed [31:0] y_in;
   logic [31:0]        z_in;
   logic [31:0]        z_fin;
   logic [31:0]        diff;
   logic [32:0]        mag;
   logic [32:0]        rnd;

   // whole pipe holds while the finished request cannot enter the queue
   assign en       = !iv_ff || out_ready;
   assign in_ready = en;

   always_comb begin
      dx_in = $signed({1'b0, sprite_x}) - $signed({1'b0, cfg.player_x});
      dy_in = $signed({1'b0, sprite_y}) - $signed({1'b0, cfg.player_y});
      x_in  = {{3{dx_in[12]}}, dx_in, 16'h0000};
      y_in  = {{3{dy_in[12]}}, dy_in, 16'h0000};
      z_in  = '0;
      if (dx_in < 0) begin
         x_in = -x_in;
         y_in = -y_in;
         z_in = HALF_TURN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cx_ff[0]   <= x_in;
         cy_ff[0]   <= y_in;
         cz_ff[0]   <= z_in;
         zero_ff[0] <= (dx_in == 0) && (dy_in == 0);
         dx_ff[0]   <= dx_in;
         dy_ff[0]   <= dy_in;
      end
   end

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      logic signed [31:0] xs;
      logic signed [31:0] ys;
      assign xs = cx_ff[k] >>> k;
      assign ys = cy_ff[k] >>> k;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else if (en) begin
            v_ff[k+1] <= v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            if (cy_ff[k] > 0) begin
               cx_ff[k+1] <= cx_ff[k] + ys;
               cy_ff[k+1] <= cy_ff[k] - xs;
               cz_ff[k+1] <= cz_ff[k] + ATAN_TABLE[k];
            end else begin
               cx_ff[k+1] <= cx_ff[k] - ys;
               cy_ff[k+1] <= cy_ff[k] + xs;
               cz_ff[k+1] <= cz_ff[k] - ATAN_TABLE[k];
            end
            zero_ff[k+1] <= zero_ff[k];
            dx_ff[k+1]   <= dx_ff[k];
            dy_ff[k+1]   <= dy_ff[k];
         end
      end
   end

   // heading difference, wrap to magnitude, round to 16-bit angle
   always_comb begin
      z_fin = zero_ff[STEPS] ? 32'h0000_0000 : cz_ff[STEPS];
      diff  = {cfg.player_heading, 16'h0000} - z_fin;
      mag   = diff[31] ? (33'h1_0000_0000 - {1'b0, diff}) : {1'b0, diff};
      rnd   = mag + 33'h0_0000_8000;
      item_in.dx   = dx_ff[STEPS];
      item_in.dy   = dy_ff[STEPS];
      item_in.diff = diff;
      item_in.boff = rnd[31:16];
      item_in.vis  = mag < VIS_LIMIT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iv_ff <= 1'b0;
      end else if (en) begin
         iv_ff <= v_ff[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = iv_ff;
   assign out_item  = item_ff;

endmodule

// ----- sv/svp_fifo.sv -----
// ----------------------------------------------------------------------------
// svp_fifo: short queue between the front end and the back end
// Register-based, first word read straight from the head entry.
// ----------------------------------------------------------------------------
module svp_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  svp_pkg::svp_item_type push_item,
   output logic                  full,
   input  logic                  pop,
   output logic                  empty,
   output svp_pkg::svp_item_type head_item
);
   import svp_pkg::*;

   svp_item_type          mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ff;
   logic [FIFO_PTR_W-1:0] rd_ff;
   logic [FIFO_PTR_W:0]   cnt_ff;
   logic                  do_push;
   logic                  do_pop;

   assign full      = cnt_ff == (FIFO_PTR_W+1)'(FIFO_DEPTH);
   assign empty     = cnt_ff == '0;
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_item = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) wr_ff <= wr_ff + 1'b1;
         if (do_pop)  rd_ff <= rd_ff + 1'b1;
         if (do_push && !do_pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

endmodule

// ----- sv/svp_back.sv -----
// ----------------------------------------------------------------------------
// svp_back: distance, perspective size and screen placement
// Bit-per-stage square root and rotation CORDIC side by side, then two
// multiplies, two restoring dividers side by side, edges and saturation.
// ----------------------------------------------------------------------------
module svp_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  svp_pkg::svp_item_type   in_item,
   output logic                    in_pop,
   output logic                    out_valid,
   input  logic                    out_ready,
   output svp_pkg::svp_result_type out_result
);
   import svp_pkg::*;

   localparam int SQ_W = 34;

   function automatic logic signed [15:0] sat16(input logic signed [OFW+1:0] v);
      logic signed [15:0] r;
      if (v > $signed((OFW+2)'(32767))) begin
         r = 16'sh7FFF;
      end else if (v < -$signed((OFW+2)'(32768))) begin
         r = -16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   logic en;

   // S0: squares and rotation prep
   logic               v0_ff;
   logic [25:0]        dx2_ff;
   logic [25:0]        dy2_ff;
   logic               flip0_ff;
   logic signed [32:0] z0_ff;
   logic               vis0_ff;
   logic [15:0]        boff0_ff;
   logic [31:0]        a_in;
   logic [31:0]        a2_in;
   logic               flip_in;

   // loop stages: sqrt and CORDIC
   logic               lv_ff    [LOOP_N+1];
   logic [SQ_W-1:0]    srem_ff  [LOOP_N+1];
   logic [15:0]        sr_ff    [LOOP_N+1];
   logic signed [31:0] lx_ff    [LOOP_N+1];
   logic signed [31:0] ly_ff    [LOOP_N+1];
   logic signed [32:0] lz_ff    [LOOP_N+1];
   logic               lflip_ff [LOOP_N+1];
   logic               lvis_ff  [LOOP_N+1];
   logic [15:0]        lboff_ff [LOOP_N+1];

   // M1: signed cosine and sine
   logic               m1v_ff;
   logic signed [31:0] ca1_ff;
   logic [31:0]        sabs1_ff;
   logic               sneg1_ff;
   logic               spos1_ff;
   logic [15:0]        d81_ff;
   logic               vis1_ff;
   logic [15:0]        boff1_ff;
   logic signed [31:0] xf;
   logic signed [31:0] yf;

   // M2: products
   logic               m2v_ff;
   logic [PERP_W-1:0]  perp2_ff;
   logic [PROD_W-1:0]  prod2_ff;
   logic [30:0]        ca2_ff;
   logic               cpos2_ff;
   logic               sneg2_ff;
   logic               spos2_ff;
   logic [15:0]        d82_ff;
   logic               vis2_ff;
   logic [15:0]        boff2_ff;
   logic [46:0]        perp_full;

   // divider stages; entry 0 is combinational from M2
   logic               dv    [DIV_N+1];
   logic [SW-1:0]      rs    [DIV_N+1];
   logic [15:0]        qs    [DIV_N+1];
   logic [OW-1:0]      ro    [DIV_N+1];
   logic [OFFS_Q_W-1:0] qo   [DIV_N+1];
   logic [30:0]        dca   [DIV_N+1];
   logic [PERP_W-1:0]  dperp [DIV_N+1];
   logic               dsat  [DIV_N+1];
   logic               dcpos [DIV_N+1];
   logic               dsneg [DIV_N+1];
   logic               dspos [DIV_N+1];
   logic [15:0]        dd8   [DIV_N+1];
   logic               dvis  [DIV_N+1];
   logic [15:0]        dboff [DIV_N+1];

   // F1: size and offset
   logic                 f1v_ff;
   logic [15:0]          size_ff;
   logic signed [OFW-1:0] offs_ff;
   logic [15:0]          d8f_ff;
   logic                 visf_ff;
   logic [15:0]          bofff_ff;
   logic signed [OFFS_Q_W:0] qsig;
   logic signed [OFFS_Q_W:0] qsh;
   logic signed [OFW-1:0] offs_in;

   // F2: output register
   logic            rv_ff;
   svp_result_type  res_ff;
   svp_result_type  res_in;
   logic signed [17:0]   top_s;
   logic signed [17:0]   bot_s;
   logic signed [OFW+1:0] left_s;
   logic signed [OFW+1:0] right_s;

   assign en        = !rv_ff || out_ready;
   assign in_pop    = en && in_valid;
   assign out_valid = rv_ff;
   assign out_result = res_ff;

   // ---- S0
   always_comb begin
      a_in    = 32'h0000_0000 - in_item.diff;
      flip_in = (a_in > QUARTER_TURN) && (a_in < FLIP_HIGH);
      a2_in   = flip_in ? (a_in - HALF_TURN) : a_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dx2_ff   <= 26'(in_item.dx * in_item.dx);
         dy2_ff   <= 26'(in_item.dy * in_item.dy);
         flip0_ff <= flip_in;
         z0_ff    <= $signed({a2_in[31], a2_in});
         vis0_ff  <= in_item.vis;
         boff0_ff <= in_item.boff;
      end
   end

   // ---- S1: loop entry
   always_ff @(posedge clock) begin
      if (reset) begin
         lv_ff[0] <= 1'b0;
      end else if (en) begin
         lv_ff[0] <= v0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         srem_ff[0]  <= SQ_W'({1'b0, dx2_ff} + {1'b0, dy2_ff}) << 6;
         sr_ff[0]    <= '0;
         lx_ff[0]    <= 32'(GAIN_COMP);
         ly_ff[0]    <= '0;
         lz_ff[0]    <= z0_ff;
         lflip_ff[0] <= flip0_ff;
         lvis_ff[0]  <= vis0_ff;
         lboff_ff[0] <= boff0_ff;
      end
   end

   for (genvar k = 0; k < LOOP_N; k++) begin : g_loop
      always_ff @(posedge clock) begin
         if (reset) begin
            lv_ff[k+1] <= 1'b0;
         end else if (en) begin
            lv_ff[k+1] <= lv_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            lflip_ff[k+1] <= lflip_ff[k];
            lvis_ff[k+1]  <= lvis_ff[k];
            lboff_ff[k+1] <= lboff_ff[k];
         end
      end

      if (k < SQRT_BITS) begin : g_sq
         localparam int J = SQRT_BITS - 1 - k;
         logic [SQ_W-1:0] trial;
         assign trial = (SQ_W'(sr_ff[k]) << (J + 1)) + (SQ_W'(1) << (2 * J));
         always_ff @(posedge clock) begin
            if (en) begin
               if (srem_ff[k] >= trial) begin
                  srem_ff[k+1] <= srem_ff[k] - trial;
                  sr_ff[k+1]   <= sr_ff[k] | (16'd1 << J);
               end else begin
                  srem_ff[k+1] <= srem_ff[k];
                  sr_ff[k+1]   <= sr_ff[k];
               end
            end
         end
      end else begin : g_sq_hold
         always_ff @(posedge clock) begin
            if (en) begin
               srem_ff[k+1] <= srem_ff[k];
               sr_ff[k+1]   <= sr_ff[k];
            end
         end
      end

      if (k < STEPS) begin : g_rot
         logic signed [31:0] xs;
         logic signed [31:0] ys;
         logic signed [32:0] at;
         assign xs = lx_ff[k] >>> k;
         assign ys = ly_ff[k] >>> k;
         assign at = $signed({1'b0, ATAN_TABLE[k]});
         always_ff @(posedge clock) begin
            if (en) begin
               if (lz_ff[k] >= 0) begin
                  lx_ff[k+1] <= lx_ff[k] - ys;
                  ly_ff[k+1] <= ly_ff[k] + xs;
                  lz_ff[k+1] <= lz_ff[k] - at;
               end else begin
                  lx_ff[k+1] <= lx_ff[k] + ys;
                  ly_ff[k+1] <= ly_ff[k] - xs;
                  lz_ff[k+1] <= lz_ff[k] + at;
               end
            end
         end
      end else begin : g_rot_hold
         always_ff @(posedge clock) begin
            if (en) begin
               lx_ff[k+1] <= lx_ff[k];
               ly_ff[k+1] <= ly_ff[k];
               lz_ff[k+1] <= lz_ff[k];
            end
         end
      end
   end

   // ---- M1
   always_comb begin
      xf = lflip_ff[LOOP_N] ? -lx_ff[LOOP_N] : lx_ff[LOOP_N];
      yf = lflip_ff[LOOP_N] ? -ly_ff[LOOP_N] : ly_ff[LOOP_N];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1v_ff <= 1'b0;
      end else if (en) begin
         m1v_ff <= lv_ff[LOOP_N];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ca1_ff   <= xf;
         sneg1_ff <= yf < 0;
         spos1_ff <= yf > 0;
         sabs1_ff <= (yf < 0) ? 32'(-yf) : 32'(yf);
         d81_ff   <= sr_ff[LOOP_N];
         vis1_ff  <= lvis_ff[LOOP_N];
         boff1_ff <= lboff_ff[LOOP_N];
      end
   end

   // ---- M2
   assign perp_full = {16'h0000, ca1_ff[30:0]} * {31'h0, d81_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         m2v_ff <= 1'b0;
      end else if (en) begin
         m2v_ff <= m1v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cpos2_ff <= ca1_ff > 0;
         perp2_ff <= (ca1_ff > 0) ? perp_full[46:17] : '0;
         prod2_ff <= PROD_W'(sabs1_ff) * PROD_W'(DPP);
         ca2_ff   <= ca1_ff[30:0];
         sneg2_ff <= sneg1_ff;
         spos2_ff <= spos1_ff;
         d82_ff   <= d81_ff;
         vis2_ff  <= vis1_ff;
         boff2_ff <= boff1_ff;
      end
   end

   // ---- dividers
   assign dv[0]    = m2v_ff;
   assign rs[0]    = SW'(SIZE_NUM);
   assign qs[0]    = '0;
   assign ro[0]    = OW'(prod2_ff);
   assign qo[0]    = '0;
   assign dca[0]   = ca2_ff;
   assign dperp[0] = perp2_ff;
   assign dsat[0]  = (perp2_ff == '0) || (SW'(perp2_ff) <= SW'(SIZE_SAT));
   assign dcpos[0] = cpos2_ff;
   assign dsneg[0] = sneg2_ff;
   assign dspos[0] = spos2_ff;
   assign dd8[0]   = d82_ff;
   assign dvis[0]  = vis2_ff;
   assign dboff[0] = boff2_ff;

   for (genvar k = 0; k < DIV_N; k++) begin : g_div
      always_ff @(posedge clock) begin
         if (reset) begin
            dv[k+1] <= 1'b0;
         end else if (en) begin
            dv[k+1] <= dv[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dca[k+1]   <= dca[k];
            dperp[k+1] <= dperp[k];
            dsat[k+1]  <= dsat[k];
            dcpos[k+1] <= dcpos[k];
            dsneg[k+1] <= dsneg[k];
            dspos[k+1] <= dspos[k];
            dd8[k+1]   <= dd8[k];
            dvis[k+1]  <= dvis[k];
            dboff[k+1] <= dboff[k];
         end
      end

      if (k < 16) begin : g_size
         localparam int J = 15 - k;
         logic [SW-1:0] dsh;
         assign dsh = SW'(dperp[k]) << J;
         always_ff @(posedge clock) begin
            if (en) begin
               if (rs[k] >= dsh) begin
                  rs[k+1] <= rs[k] - dsh;
                  qs[k+1] <= qs[k] | (16'd1 << J);
               end else begin
                  rs[k+1] <= rs[k];
                  qs[k+1] <= qs[k];
               end
            end
         end
      end else begin : g_size_hold
         always_ff @(posedge clock) begin
            if (en) begin
               rs[k+1] <= rs[k];
               qs[k+1] <= qs[k];
            end
         end
      end

      if (k < OFFS_Q_W) begin : g_offs
         localparam int J = OFFS_Q_W - 1 - k;
         logic [OW-1:0] dsh;
         assign dsh = OW'(dca[k]) << J;
         always_ff @(posedge clock) begin
            if (en) begin
               if (ro[k] >= dsh) begin
                  ro[k+1] <= ro[k] - dsh;
                  qo[k+1] <= qo[k] | (OFFS_Q_W'(1) << J);
               end else begin
                  ro[k+1] <= ro[k];
                  qo[k+1] <= qo[k];
               end
            end
         end
      end else begin : g_offs_hold
         always_ff @(posedge clock) begin
            if (en) begin
               ro[k+1] <= ro[k];
               qo[k+1] <= qo[k];
            end
         end
      end
   end

   // ---- F1: quotient truncates toward zero, then floors to whole pixels
   always_comb begin
      qsig = dsneg[DIV_N] ? -$signed({1'b0, qo[DIV_N]}) : $signed({1'b0, qo[DIV_N]});
      qsh  = qsig >>> 16;
      if (dcpos[DIV_N]) begin
         offs_in = OFW'(qsh);
      end else if (dspos[DIV_N]) begin
         offs_in = $signed(OFW'(1) << 20);
      end else begin
         offs_in = -$signed(OFW'(1) << 20);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1v_ff <= 1'b0;
      end else if (en) begin
         f1v_ff <= dv[DIV_N];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         size_ff  <= dsat[DIV_N] ? 16'hFFFF : qs[DIV_N];
         offs_ff  <= offs_in;
         d8f_ff   <= dd8[DIV_N];
         visf_ff  <= dvis[DIV_N];
         bofff_ff <= dboff[DIV_N];
      end
   end

   // ---- F2: edges, clamps, hidden sprites zeroed apart from bearing
   always_comb begin
      top_s   = $signed(18'(SCREEN_HEIGHT / 2)) - $signed({3'b000, size_ff[15:1]});
      bot_s   = top_s + $signed({2'b00, size_ff});
      left_s  = $signed((OFW+2)'(SCREEN_WIDTH / 2)) + (OFW+2)'(offs_ff)
                - $signed({{(OFW-13){1'b0}}, size_ff[15:1]});
      right_s = left_s + $signed({{(OFW-14){1'b0}}, size_ff});

      res_in                = '0;
      res_in.bearing_offset = bofff_ff;
      if (visf_ff) begin
         res_in.visible         = 1'b1;
         res_in.sprite_distance = d8f_ff;
         res_in.projected_size  = size_ff;
         res_in.top_row         = (top_s < 0) ? 10'd0 : top_s[9:0];
         res_in.bottom_row      = (bot_s > $signed(18'(SCREEN_HEIGHT))) ?
                                  10'(SCREEN_HEIGHT) : bot_s[9:0];
         res_in.left_column     = sat16(left_s);
         res_in.right_column    = sat16(right_s);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else if (en) begin
         rv_ff <= f1v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

endmodule
